@@ rtl/core/ssfb_pkg.sv @@
// Shared types, constants and a helper function for the sensor sample filter bank.
package ssfb_pkg;

    localparam int SMP_W     = 16;
    localparam int PROD_W    = 2 * SMP_W;
    localparam int OUT_W     = 24;
    localparam int FRAC_W    = 8;
    localparam int SAT_W     = 40;
    localparam int CFG_IDX_W = 4;
    localparam int COEF_COUNT = 6;

    localparam int MAF_TAPS_DEF = 4;
    localparam int FIR_TAPS_DEF = 6;

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [OUT_W-1:0]  t_q8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IIR_WEIGHT_OLD = 4'd0,
        REG_IIR_WEIGHT_NEW = 4'd1,
        REG_FIR_COEF_0     = 4'd2,
        REG_FIR_COEF_1     = 4'd3,
        REG_FIR_COEF_2     = 4'd4,
        REG_FIR_COEF_3     = 4'd5,
        REG_FIR_COEF_4     = 4'd6,
        REG_FIR_COEF_5     = 4'd7
    } t_reg_idx;

    localparam t_smp WEIGHT_RESET = 16'sd16384;
    localparam t_smp COEF_RESET [COEF_COUNT] = '{
        16'sd865, 16'sd4604, 16'sd10915, 16'sd10915, 16'sd4604, 16'sd865
    };

    typedef struct packed {
        t_smp raw_sample;
        t_q8  window_average;
        t_q8  blend_output;
        t_q8  fir_output;
    } t_result;

    // Drops seven fraction bits (rounding toward minus infinity) and clamps to 24 bits.
    function automatic t_q8 sat_q8(input logic signed [SAT_W-1:0] v);
        logic signed [SAT_W-1:0] sh;
        t_q8 res;
        sh = v >>> 7;
        if (sh[SAT_W-1:OUT_W-1] == '0 || sh[SAT_W-1:OUT_W-1] == '1) begin
            res = sh[OUT_W-1:0];
        end else if (sh[SAT_W-1]) begin
            res = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

@@ rtl/core/ssfb_if.sv @@
// Handshake channels of the filter bank: sample requests, results and register writes.
interface ssfb_sample_if import ssfb_pkg::*; ();
    logic valid;
    logic ready;
    t_smp sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ssfb_result_if import ssfb_pkg::*; ();
    logic valid;
    logic ready;
    t_smp raw_sample;
    t_q8  window_average;
    t_q8  blend_output;
    t_q8  fir_output;

    modport source (output valid, output raw_sample, output window_average,
                    output blend_output, output fir_output, input ready);
    modport sink   (input valid, input raw_sample, input window_average,
                    input blend_output, input fir_output, output ready);
endinterface

interface ssfb_cfg_if import ssfb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_smp                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/ssfb_fir_cell.sv @@
// One FIR tap: holds a sample, passes it to the older neighbor and registers its product.
module ssfb_fir_cell import ssfb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_smp  i_sample,
    input  t_smp  i_coef,
    output t_smp  o_sample,
    output t_prod o_product
);

    t_smp  r_sample;
    t_prod r_product;
    t_prod n_product;

    always_comb begin
        n_product = PROD_W'(i_coef) * PROD_W'(i_sample);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample <= '0;
        end else if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    // The product belongs to the request that shifts in, so it loads on the same edge.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_product <= n_product;
        end
    end

    assign o_sample  = r_sample;
    assign o_product = r_product;

endmodule

@@ rtl/core/ssfb_avg_div.sv @@
// Divides the window sum, scaled by 256, by the tap count using a reciprocal multiply.
module ssfb_avg_div import ssfb_pkg::*; #(
    parameter int MAF_TAPS = MAF_TAPS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  logic signed [SMP_W+$clog2(MAF_TAPS)-1:0] i_sum,
    output t_q8                                    o_average
);

    localparam int SUM_W = SMP_W + $clog2(MAF_TAPS);
    localparam int A_W   = SUM_W + FRAC_W;
    localparam int P_W   = 2 * A_W;
    localparam int R_W   = $clog2(MAF_TAPS) + 1;
    localparam logic [A_W:0]   RECIP   = (A_W+1)'((64'd1 << A_W) / MAF_TAPS);
    localparam logic [R_W-1:0] DIVISOR = R_W'(MAF_TAPS);

    logic [SUM_W-1:0] n_mag;
    logic [A_W-1:0]   n_scaled;
    logic [P_W-1:0]   n_prod;
    logic [P_W-1:0]   r_prod;
    logic [R_W-1:0]   r_alo;
    logic             r_neg2;
    logic [OUT_W-1:0] n_q0;
    logic [R_W-1:0]   n_rem;
    logic [OUT_W-1:0] r_q0;
    logic [R_W-1:0]   r_rem;
    logic             r_neg3;
    logic [OUT_W-1:0] w_quot;

    // Stage one: magnitude times the truncated reciprocal, which is low by at most one.
    always_comb begin
        n_mag    = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
        n_scaled = {n_mag, {FRAC_W{1'b0}}};
        n_prod   = P_W'(n_scaled) * P_W'(RECIP);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_alo  <= n_scaled[R_W-1:0];
            r_neg2 <= i_sum[SUM_W-1];
        end
    end

    // Stage two: the remainder is below twice the divisor, so its low bits suffice.
    always_comb begin
        n_q0  = r_prod[A_W +: OUT_W];
        n_rem = r_alo - R_W'(n_q0[R_W-1:0] * DIVISOR);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q0   <= n_q0;
            r_rem  <= n_rem;
            r_neg3 <= r_neg2;
        end
    end

    assign w_quot    = r_q0 + OUT_W'(r_rem >= DIVISOR);
    assign o_average = r_neg3 ? -w_quot : w_quot;

endmodule

@@ rtl/core/sensor_sample_filter_bank.sv @@
// Top level of the sensor sample filter bank: moving average, two-sample blend and FIR.
//
// Each request on i_sample carries one signed 16-bit reading. For each request one
// result leaves on o_result with four fields: the reading itself, the moving average
// over the last MAF_TAPS readings, a blend of the previous and current reading
// weighted by two Q1.15 registers, and a FIR_TAPS-tap FIR filter with Q1.15
// coefficients. The three filter outputs are signed with 8 fractional bits; the
// blend and FIR outputs saturate, the average truncates toward zero.
// Registers are written over i_cfg (index 0 and 1 are the blend weights, index 2 and
// up the FIR coefficients, oldest tap first); the channel is always ready, and writes
// are meant to happen only while no request is in flight. Unknown indexes are ignored.
// A result passes the tap-cell product registers, the adder stage, the saturation
// stage with the two-stage reciprocal divider of the average, and the output register;
// a new request can be accepted every cycle while the skid register is empty.
// When the receiver stalls, the output register and one skid register hold results;
// once the skid register is full the pipeline freezes and i_sample.ready drops, and it
// rises again the cycle after the skid entry drains. Reset clears all sample history,
// the running sum and the previous sample to zero and reloads the register defaults.
module sensor_sample_filter_bank import ssfb_pkg::*; #(
    parameter int MAF_TAPS = MAF_TAPS_DEF,
    parameter int FIR_TAPS = FIR_TAPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ssfb_sample_if.sink       i_sample,
    ssfb_result_if.source     o_result,
    ssfb_cfg_if.sink          i_cfg
);

    localparam int SUM_W  = SMP_W + $clog2(MAF_TAPS);
    localparam int FSUM_W = PROD_W + $clog2(FIR_TAPS);
    localparam int BSUM_W = PROD_W + 1;

    // Configuration registers. The coefficient for tap k weighs the k-th oldest sample.
    t_smp r_w_old;
    t_smp r_w_new;
    t_smp r_coef [FIR_TAPS];

    // Pipeline control: everything advances unless the skid register holds a result.
    logic w_en;
    logic w_acc;
    logic r_v1;
    logic r_v2;
    logic r_v3;

    // Moving average history and its running sum.
    t_smp               r_maf [MAF_TAPS];
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;

    // Blend history and products.
    t_smp  r_prev;
    t_prod r_bl_old_p;
    t_prod r_bl_new_p;

    // FIR cell chain.
    t_smp  w_fir_in   [FIR_TAPS];
    t_smp  w_fir_smp  [FIR_TAPS];
    t_prod w_fir_prod [FIR_TAPS];

    t_smp r_raw1;
    t_smp r_raw2;
    t_smp r_raw3;

    logic signed [FSUM_W-1:0] n_fir_sum;
    logic signed [FSUM_W-1:0] r_fir_sum;
    logic signed [BSUM_W-1:0] n_bl_sum;
    logic signed [BSUM_W-1:0] r_bl_sum;
    t_q8 r_fir_sat;
    t_q8 r_bl_sat;
    t_q8 w_average;

    // Output register and skid register.
    t_result n_res;
    t_result r_out;
    t_result r_sk;
    logic    r_ov;
    logic    r_skv;
    logic    w_take;

    assign w_en   = !r_skv;
    assign w_acc  = i_sample.valid && w_en;
    assign w_take = r_ov && o_result.ready;

    assign i_sample.ready = w_en;
    assign i_cfg.ready    = 1'b1;

    // Register writes. An index outside the list matches no arm and changes nothing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_old <= WEIGHT_RESET;
            r_w_new <= WEIGHT_RESET;
            for (int k = 0; k < FIR_TAPS; k++) begin
                r_coef[k] <= COEF_RESET[k];
            end
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_IIR_WEIGHT_OLD: begin
                    r_w_old <= i_cfg.data;
                end
                REG_IIR_WEIGHT_NEW: begin
                    r_w_new <= i_cfg.data;
                end
                default: begin
                    for (int k = 0; k < FIR_TAPS; k++) begin
                        if (i_cfg.index == CFG_IDX_W'(REG_FIR_COEF_0) + CFG_IDX_W'(k)) begin
                            r_coef[k] <= i_cfg.data;
                        end
                    end
                end
            endcase
        end
    end

    // Valid bits of the three internal stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_acc;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // The running sum adds the new sample and drops the one that leaves the window,
    // which always equals the sum of the window after the write.
    assign n_sum = r_sum + SUM_W'(i_sample.sample) - SUM_W'(r_maf[0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAF_TAPS; k++) begin
                r_maf[k] <= '0;
            end
            r_sum  <= '0;
            r_prev <= '0;
        end else if (w_acc) begin
            for (int k = 0; k < MAF_TAPS - 1; k++) begin
                r_maf[k] <= r_maf[k+1];
            end
            r_maf[MAF_TAPS-1] <= i_sample.sample;
            r_sum  <= n_sum;
            r_prev <= i_sample.sample;
        end
    end

    // First stage payload: blend products and the raw sample.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_bl_old_p <= PROD_W'(r_w_old) * PROD_W'(r_prev);
            r_bl_new_p <= PROD_W'(r_w_new) * PROD_W'(i_sample.sample);
            r_raw1     <= i_sample.sample;
        end
    end

    // The chain of FIR cells; the newest sample enters at the last cell.
    for (genvar k = 0; k < FIR_TAPS; k++) begin : g_fir
        if (k == FIR_TAPS - 1) begin : g_head
            assign w_fir_in[k] = i_sample.sample;
        end else begin : g_link
            assign w_fir_in[k] = w_fir_smp[k+1];
        end

        ssfb_fir_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (w_acc),
            .i_sample  (w_fir_in[k]),
            .i_coef    (r_coef[k]),
            .o_sample  (w_fir_smp[k]),
            .o_product (w_fir_prod[k])
        );
    end

    // Second stage: sum the products.
    always_comb begin
        n_fir_sum = '0;
        for (int k = 0; k < FIR_TAPS; k++) begin
            n_fir_sum = n_fir_sum + FSUM_W'(w_fir_prod[k]);
        end
        n_bl_sum = BSUM_W'(r_bl_old_p) + BSUM_W'(r_bl_new_p);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fir_sum <= n_fir_sum;
            r_bl_sum  <= n_bl_sum;
            r_raw2    <= r_raw1;
        end
    end

    // Third stage: scale to 8 fractional bits and saturate.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fir_sat <= sat_q8(SAT_W'(r_fir_sum));
            r_bl_sat  <= sat_q8(SAT_W'(r_bl_sum));
            r_raw3    <= r_raw2;
        end
    end

    // The divider runs in step with stages two and three.
    ssfb_avg_div #(
        .MAF_TAPS (MAF_TAPS)
    ) u_avg_div (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_sum     (r_sum),
        .o_average (w_average)
    );

    always_comb begin
        n_res.raw_sample     = r_raw3;
        n_res.window_average = w_average;
        n_res.blend_output   = r_bl_sat;
        n_res.fir_output     = r_fir_sat;
    end

    // Output register with one skid entry. A finished result goes to the output
    // register when it is free or being taken, and otherwise into the skid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_skv <= 1'b0;
        end else if (r_skv) begin
            if (w_take) begin
                r_skv <= 1'b0;
            end
        end else if (r_v3) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
            end else begin
                r_skv <= 1'b1;
            end
        end else if (w_take) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skv) begin
            if (w_take) begin
                r_out <= r_sk;
            end
        end else if (r_v3) begin
            if (!r_ov || w_take) begin
                r_out <= n_res;
            end else begin
                r_sk <= n_res;
            end
        end
    end

    assign o_result.valid          = r_ov;
    assign o_result.raw_sample     = r_out.raw_sample;
    assign o_result.window_average = r_out.window_average;
    assign o_result.blend_output   = r_out.blend_output;
    assign o_result.fir_output     = r_out.fir_output;

endmodule

@@ verif/sensor_sample_filter_bank_checker.sv @@
// Checker for the sensor sample filter bank: predicts each result and compares it with the block.
`timescale 1ns / 1ps
module sensor_sample_filter_bank_checker import ssfb_pkg::*; #(
    parameter int MAF_TAPS = MAF_TAPS_DEF,
    parameter int FIR_TAPS = FIR_TAPS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    ssfb_sample_if i_sample,
    ssfb_result_if i_result,
    ssfb_cfg_if    i_cfg,
    output int     o_mismatch_count,
    output int     o_pending_count,
    output int     o_checked_count
);

    localparam int     REPORT_LIMIT = 10;
    localparam longint Q8_MAX       = 8388607;
    localparam longint Q8_MIN       = -8388608;

    // Shadow copy of the sample history and the register file.
    t_smp    avg_window [MAF_TAPS];
    int      avg_slot;
    t_smp    last_sample;
    t_smp    fir_line [FIR_TAPS];
    t_smp    weight_old;
    t_smp    weight_new;
    t_smp    fir_coef [COEF_COUNT];

    t_result filter_results_due [$];
    int      mismatches;
    int      checked;

    // Drops seven fraction bits toward minus infinity and clamps to the 24-bit output.
    function automatic t_q8 round_and_clamp(input longint acc);
        longint shifted;
        t_q8    res;
        shifted = acc >>> 7;
        if (shifted > Q8_MAX) begin
            res = t_q8'(Q8_MAX);
        end else if (shifted < Q8_MIN) begin
            res = t_q8'(Q8_MIN);
        end else begin
            res = t_q8'(shifted);
        end
        return res;
    endfunction

    // Advances all three filters by one sample and returns the four outputs it produces.
    function automatic t_result filter_sample(input t_smp s);
        t_result r;
        longint  win_sum;
        longint  blend_acc;
        longint  fir_acc;
        avg_window[avg_slot] = s;
        avg_slot = (avg_slot + 1 >= MAF_TAPS) ? 0 : avg_slot + 1;
        win_sum = 0;
        for (int i = 0; i < MAF_TAPS; i++) begin
            win_sum += longint'(avg_window[i]);
        end
        r.window_average = t_q8'((win_sum * 256) / MAF_TAPS);

        blend_acc = longint'(weight_old) * longint'(last_sample)
                  + longint'(weight_new) * longint'(s);
        r.blend_output = round_and_clamp(blend_acc);
        last_sample = s;

        for (int i = 0; i < FIR_TAPS - 1; i++) begin
            fir_line[i] = fir_line[i + 1];
        end
        fir_line[FIR_TAPS - 1] = s;
        fir_acc = 0;
        for (int i = 0; i < FIR_TAPS && i < COEF_COUNT; i++) begin
            fir_acc += longint'(fir_coef[i]) * longint'(fir_line[i]);
        end
        r.fir_output = round_and_clamp(fir_acc);
        r.raw_sample = s;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < MAF_TAPS; i++) begin
                avg_window[i] = '0;
            end
            for (int i = 0; i < FIR_TAPS; i++) begin
                fir_line[i] = '0;
            end
            for (int i = 0; i < COEF_COUNT; i++) begin
                fir_coef[i] = COEF_RESET[i];
            end
            avg_slot    = 0;
            last_sample = '0;
            weight_old  = WEIGHT_RESET;
            weight_new  = WEIGHT_RESET;
            filter_results_due.delete();
            mismatches  = 0;
            checked     = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_IIR_WEIGHT_OLD: weight_old = i_cfg.data;
                    REG_IIR_WEIGHT_NEW: weight_new = i_cfg.data;
                    REG_FIR_COEF_0, REG_FIR_COEF_1, REG_FIR_COEF_2,
                    REG_FIR_COEF_3, REG_FIR_COEF_4, REG_FIR_COEF_5: begin
                        fir_coef[int'(i_cfg.index) - int'(REG_FIR_COEF_0)] = i_cfg.data;
                    end
                    default: ;
                endcase
            end

            // Results are checked before this edge's request is predicted, so a stray
            // result can never be matched against an expectation made at the same edge.
            if (i_result.valid && i_result.ready) begin
                got.raw_sample     = i_result.raw_sample;
                got.window_average = i_result.window_average;
                got.blend_output   = i_result.blend_output;
                got.fir_output     = i_result.fir_output;
                if (filter_results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("unexpected result: raw %0d avg %0d blend %0d fir %0d",
                                 got.raw_sample, got.window_average,
                                 got.blend_output, got.fir_output);
                    end
                end else begin
                    want = filter_results_due.pop_front();
                    checked++;
                    if (want.raw_sample !== got.raw_sample
                            || want.window_average !== got.window_average
                            || want.blend_output !== got.blend_output
                            || want.fir_output !== got.fir_output) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("result %0d mismatch (expected / actual):", checked);
                            $display("  raw %0d / %0d  avg %0d / %0d",
                                     want.raw_sample, got.raw_sample,
                                     want.window_average, got.window_average);
                            $display("  blend %0d / %0d  fir %0d / %0d",
                                     want.blend_output, got.blend_output,
                                     want.fir_output, got.fir_output);
                        end
                    end
                end
            end

            if (i_sample.valid && i_sample.ready) begin
                filter_results_due.push_back(filter_sample(i_sample.sample));
            end
        end
        o_mismatch_count <= mismatches;
        o_pending_count  <= filter_results_due.size();
        o_checked_count  <= checked;
    end

endmodule

@@ verif/sensor_sample_filter_bank_tb.sv @@
// Testbench top for the sensor sample filter bank: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module sensor_sample_filter_bank_tb;
    import ssfb_pkg::*;

    localparam int   CYCLE_LIMIT          = 400000;
    localparam int   RESET_CYCLES         = 10;
    localparam int   RANDOM_SEGMENT_ITEMS = 334;
    localparam int   SETTLE_CYCLES        = 10;
    localparam t_smp SAMPLE_MAX           = 16'sh7fff;
    localparam t_smp SAMPLE_MIN           = 16'sh8000;

    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    // Indexes above the last coefficient are not mapped to any register.
    localparam t_cfg_index FIRST_UNMAPPED_IDX = 4'd8;
    localparam t_cfg_index LAST_UNMAPPED_IDX  = 4'd15;

    // Register file contents that the run steps through between phases.
    typedef enum int {
        SET_DEFAULTS,
        SET_ALL_MAX,
        SET_ALL_MIN,
        SET_ALTERNATING,
        SET_RANDOM
    } t_filter_setting;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int sender_idle_pct;
    int receiver_idle_pct;
    int cycle_count = 0;
    int samples_sent = 0;
    int settings_applied = 0;
    int mismatch_count;
    int pending_count;
    int checked_count;

    ssfb_sample_if sample_bus ();
    ssfb_result_if result_bus ();
    ssfb_cfg_if    cfg_bus ();

    sensor_sample_filter_bank u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    sensor_sample_filter_bank_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_sample         (sample_bus),
        .i_result         (result_bus),
        .i_cfg            (cfg_bus),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count),
        .o_checked_count  (checked_count)
    );

    // 10 ns clock, first rising edge at 5 ns.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, pending_count);
            $display("simulation failed");
            $finish;
        end
    end

    // The result receiver stalls at random; with a zero idle share it is always ready.
    always @(posedge i_clk) begin
        result_bus.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
    end

    // Stops offering requests and waits until the checker holds no open expectation.
    // The pending count comes from a register in the checker, so the task waits on the clock before it first reads it.
    task automatic wait_for_results();
        sample_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    // Offers one sample request, with random gaps in front of it, and returns at the
    // edge where it is accepted. Valid stays high so back-to-back requests need no
    // second assignment in the same step.
    task automatic send_sample(input t_smp value);
        while ($urandom_range(99, 0) < sender_idle_pct) begin
            sample_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= value;
        do @(posedge i_clk); while (!sample_bus.ready);
        samples_sent++;
    endtask

    // One register write request; the caller lowers valid after the last write.
    task automatic write_register(input t_cfg_index idx, input t_smp value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
    endtask

    // Drains the pipeline, then rewrites every register and pokes one unmapped index,
    // which the block must ignore.
    task automatic apply_setting(input t_filter_setting setting);
        t_smp value;
        wait_for_results();
        for (int k = REG_IIR_WEIGHT_OLD; k <= REG_FIR_COEF_5; k++) begin
            case (setting)
                SET_DEFAULTS: begin
                    value = (k < REG_FIR_COEF_0) ? WEIGHT_RESET
                                                 : COEF_RESET[k - REG_FIR_COEF_0];
                end
                SET_ALL_MAX:     value = SAMPLE_MAX;
                SET_ALL_MIN:     value = SAMPLE_MIN;
                SET_ALTERNATING: value = k[0] ? SAMPLE_MIN : SAMPLE_MAX;
                default:         value = t_smp'($urandom);
            endcase
            write_register(t_cfg_index'(k), value);
        end
        write_register(t_cfg_index'($urandom_range(LAST_UNMAPPED_IDX, FIRST_UNMAPPED_IDX)),
                       t_smp'($urandom));
        cfg_bus.valid <= 1'b0;
        settings_applied++;
    endtask

    // Random readings, weighted toward the rails, near-zero values and repeats. Runs of a
    // repeated rail value fill all windows and can saturate the blend and FIR outputs.
    function automatic t_smp pick_sample(input t_smp previous);
        t_smp value;
        case ($urandom_range(9, 0))
            0:       value = SAMPLE_MAX;
            1:       value = SAMPLE_MIN;
            2:       value = t_smp'($urandom_range(16, 0)) - 16'sd8;
            3, 4:    value = previous;
            default: value = t_smp'($urandom);
        endcase
        return value;
    endfunction

    // One stretch of random requests under a single register setting. Now and then
    // the sender holds off until every expected result has come back.
    task automatic run_random_segment(input t_filter_setting setting, input int items);
        t_smp value;
        apply_setting(setting);
        value = '0;
        for (int n = 0; n < items; n++) begin
            value = pick_sample(value);
            send_sample(value);
            if ($urandom_range(199, 0) == 0) begin
                wait_for_results();
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        sample_bus.valid  <= 1'b0;
        sample_bus.sample <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= '0;
        cfg_bus.data      <= '0;
        sender_idle_pct   = 36;
        receiver_idle_pct = 65;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset register values: zero and unit readings, then
        // the positive rail long enough to fill the averaging window, then the negative rail.
        send_sample('0);
        send_sample(16'sd1);
        send_sample(-16'sd1);
        repeat (4) send_sample(SAMPLE_MAX);
        repeat (4) send_sample(SAMPLE_MIN);

        // All weights and taps at the positive rail: a full line of positive rail
        // readings saturates high, and two negative readings swing the blend low.
        apply_setting(SET_ALL_MAX);
        repeat (6) send_sample(SAMPLE_MAX);
        repeat (2) send_sample(SAMPLE_MIN);

        // All weights and taps at the negative rail: negative readings times negative
        // weights overflow upward, positive readings overflow downward.
        apply_setting(SET_ALL_MIN);
        repeat (3) send_sample(SAMPLE_MIN);
        repeat (3) send_sample(SAMPLE_MAX);

        // Slow sender, slower receiver.
        run_random_segment(SET_RANDOM, RANDOM_SEGMENT_ITEMS);
        run_random_segment(SET_DEFAULTS, RANDOM_SEGMENT_ITEMS);

        // The reverse: the receiver keeps up better than the sender.
        sender_idle_pct   = 65;
        receiver_idle_pct = 36;
        run_random_segment(SET_ALTERNATING, RANDOM_SEGMENT_ITEMS);
        run_random_segment(SET_RANDOM, RANDOM_SEGMENT_ITEMS);

        // Full rate on both sides.
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_segment(SET_ALL_MIN, RANDOM_SEGMENT_ITEMS);
        run_random_segment(SET_RANDOM, RANDOM_SEGMENT_ITEMS);

        // Let the last results arrive, then keep watching for strays.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("sent %0d sample requests under %0d register settings plus reset values,",
                 samples_sent, settings_applied);
        $display("checked %0d results across throttled, reversed and full-rate pacing",
                 checked_count);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/ssfb_pkg.sv
rtl/core/ssfb_if.sv
rtl/core/ssfb_fir_cell.sv
rtl/core/ssfb_avg_div.sv
rtl/core/sensor_sample_filter_bank.sv
verif/sensor_sample_filter_bank_checker.sv
verif/sensor_sample_filter_bank_tb.sv
